>>> rtl/cp_tensor_predict_rmse_defines.svh
// Assertion helpers used by cp_tensor_predict_rmse.sv.
`ifndef CP_TENSOR_PREDICT_RMSE_DEFINES_SVH
`define CP_TENSOR_PREDICT_RMSE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define CPTP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CPTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cptp_pkg.sv
`default_nettype none
package cptp_pkg;

    localparam int MAX_MODES     = 4;
    localparam int MAX_LATENTS   = 32;
    localparam int ROWS_PER_MODE = 1024;

    localparam int MODE_W  = 2;
    localparam int LAT_W   = 5;
    localparam int IDX_W   = 10;
    localparam int ADDR_W  = MODE_W + LAT_W + IDX_W;
    localparam int STORE_DEPTH = MAX_MODES * MAX_LATENTS * ROWS_PER_MODE;

    localparam int VAL_W   = 32;
    localparam int SUM_W   = VAL_W + $clog2(MAX_LATENTS) + 1;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam int SQ_IN_W  = 62;
    localparam int SQ_OUT_W = 31;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_EVAL   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic [1:0] CFG_GLOBAL_MEAN  = 2'd0;
    localparam logic [1:0] CFG_EPOCH_COUNT  = 2'd1;
    localparam logic [1:0] CFG_MODE_COUNT   = 2'd2;
    localparam logic [1:0] CFG_LATENT_COUNT = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_PRED,
        ST_AVG,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MUL_VAR,
        ST_VAR,
        ST_MUL_RAW,
        ST_ACC_RAW,
        ST_MUL_AVG,
        ST_ACC_AVG,
        ST_DIV_RAW,
        ST_SQRT_RAW,
        ST_DIV_AVG,
        ST_SQRT_AVG,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

>>> rtl/cp_tensor_predict_rmse.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   action, load_*, *_index, observed, prior_*
// out      output     out_valid/out_ready new_mean, new_var, rmse_*, is_report, no_data
// cfg      input      cfg_we              cfg_index, cfg_data
//
// A load writes the factor memory as it is taken. An evaluation reads one
// factor per mode and latent through the single read port (none with no
// latents), then uses the 64-step divider when epoch_count is nonzero.
// A finish with entries makes two divider passes and up to two 31-step root
// passes (skipped when the mean square overflows); without entries, none.
// in_ready is high only while no item is in work; a finished result waits in
// the output register while the next item is taken. Reset clears control and
// accumulators; the factor memory holds whatever was loaded.
`default_nettype none
`include "cp_tensor_predict_rmse_defines.svh"
module cp_tensor_predict_rmse (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [1:0]  load_mode,
    input  wire logic [4:0]  load_latent,
    input  wire logic [9:0]  load_index,
    input  wire logic signed [31:0] load_value,
    input  wire logic [9:0]  first_index,
    input  wire logic [9:0]  second_index,
    input  wire logic [9:0]  third_index,
    input  wire logic [9:0]  fourth_index,
    input  wire logic signed [31:0] observed,
    input  wire logic signed [31:0] prior_mean,
    input  wire logic signed [31:0] prior_var,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] new_mean,
    output logic signed [31:0] new_var,
    output logic [30:0]      rmse_raw,
    output logic [30:0]      rmse_averaged,
    output logic             is_report,
    output logic             no_data
);

    localparam int MODE_W = cptp_pkg::MODE_W;
    localparam int LAT_W  = cptp_pkg::LAT_W;
    localparam int IDX_W  = cptp_pkg::IDX_W;
    localparam int SUM_W  = cptp_pkg::SUM_W;
    localparam int N_W    = cptp_pkg::DIV_N_W;
    localparam int D_W    = cptp_pkg::DIV_D_W;
    localparam int SQI_W  = cptp_pkg::SQ_IN_W;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [30:0] RMSE_MAX = '1;

    // configuration
    logic signed [31:0] global_mean_reg;
    logic [15:0]        epoch_count_reg;
    logic [2:0]         mode_count_reg;
    logic [5:0]         latent_count_reg;

    cptp_pkg::state_t state_reg, state_next;

    // entry data
    logic [IDX_W-1:0]   idx_reg [cptp_pkg::MAX_MODES];
    logic signed [31:0] obs_reg, pm_reg, pv_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [LAT_W-1:0]   lat_reg;

    // factor pipeline
    logic               rd_v_reg, rd_first_reg, rd_last_reg;
    logic signed [31:0] t_reg, term_reg;
    logic               term_v_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [31:0] pred_reg, mean_reg, var_reg;
    logic [63:0]        prod_reg;

    // accumulators and result
    logic [63:0]        raw_sum_reg, avg_sum_reg;
    logic [31:0]        entry_count_reg;
    logic [30:0]        rr_reg, ra_reg;
    logic               rep_reg, nod_reg;

    logic               out_valid_reg, is_report_reg, no_data_reg;
    logic signed [31:0] new_mean_reg, new_var_reg;
    logic [30:0]        rmse_raw_reg, rmse_avg_reg;

    // clamped counts
    logic [2:0]         mc_eff;
    logic [5:0]         lc_eff;
    logic [MODE_W-1:0]  mc_last;
    logic [LAT_W-1:0]   lc_last;

    logic               in_xfer, out_free;
    logic               ram_we, ram_re;
    logic [cptp_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]        ram_rdata;

    logic signed [63:0] fprod;
    logic signed [31:0] t_new;
    logic signed [32:0] delta, rest, err_raw, err_avg;
    logic [32:0]        delta_abs, rest_abs, err_raw_abs, err_avg_abs;
    logic [32:0]        q_abs;
    logic signed [33:0] mean_wide;
    logic signed [SUM_W:0] pred_wide;
    logic signed [49:0] var_wide;
    logic [64:0]        raw_add, avg_add;

    logic               div_start, sq_start;
    logic [N_W-1:0]     div_a, quotient;
    logic [D_W-1:0]     div_b;
    logic [SQI_W-1:0]   sq_a;
    logic [cptp_pkg::SQ_OUT_W-1:0] root;
    cptp_pkg::unit_stat_t div_stat, sq_stat;

    assign mc_eff  = (mode_count_reg < 3'd2) ? 3'd2 :
                     (mode_count_reg > 3'(cptp_pkg::MAX_MODES)) ?
                         3'(cptp_pkg::MAX_MODES) : mode_count_reg;
    assign lc_eff  = (latent_count_reg > 6'(cptp_pkg::MAX_LATENTS)) ?
                         6'(cptp_pkg::MAX_LATENTS) : latent_count_reg;
    assign mc_last = MODE_W'(mc_eff - 3'd1);
    assign lc_last = LAT_W'(lc_eff - 6'd1);

    assign in_ready = (state_reg == cptp_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign ram_we    = in_xfer && (action == cptp_pkg::ACT_LOAD);
    assign ram_waddr = {load_mode, load_latent, load_index};
    assign ram_re    = (state_reg == cptp_pkg::ST_RUN);
    assign ram_raddr = {mode_reg, lat_reg, idx_reg[mode_reg]};

    cptp_factor_ram #(
        .DEPTH (cptp_pkg::STORE_DEPTH),
        .WIDTH (32)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (load_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cptp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (quotient),
        .stat     (div_stat)
    );

    cptp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_a),
        .root     (root),
        .stat     (sq_stat)
    );

    // datapath arithmetic
    assign fprod = t_reg * $signed(ram_rdata);
    always_comb
    begin
        if (rd_first_reg)
            t_new = $signed(ram_rdata);
        else if (fprod[63:47] == {17{fprod[63]}})
            t_new = fprod[47:16];
        else
            t_new = fprod[63] ? S32_MIN : S32_MAX;
    end

    assign pred_wide = (SUM_W+1)'(global_mean_reg) + (SUM_W+1)'(sum_reg);
    assign delta     = 33'(pred_reg) - 33'(pm_reg);
    assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
    assign q_abs     = quotient[32:0];
    assign mean_wide = 34'(pm_reg) + (delta[32] ? -$signed({1'b0, q_abs})
                                                : $signed({1'b0, q_abs}));
    assign rest      = 33'(pred_reg) - 33'(mean_reg);
    assign rest_abs  = rest[32] ? 33'(-rest) : 33'(rest);
    assign var_wide  = 50'(pv_reg) + $signed({2'b00, prod_reg[63:16]});
    assign err_raw   = 33'(obs_reg) - 33'(pred_reg);
    assign err_avg   = 33'(obs_reg) - 33'(mean_reg);
    assign err_raw_abs = err_raw[32] ? 33'(-err_raw) : 33'(err_raw);
    assign err_avg_abs = err_avg[32] ? 33'(-err_avg) : 33'(err_avg);
    assign raw_add   = {1'b0, raw_sum_reg} + {17'b0, prod_reg[63:16]};
    assign avg_add   = {1'b0, avg_sum_reg} + {17'b0, prod_reg[63:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_mean_reg  <= '0;
            epoch_count_reg  <= '0;
            mode_count_reg   <= 3'd3;
            latent_count_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cptp_pkg::CFG_GLOBAL_MEAN:  global_mean_reg  <= cfg_data;
                cptp_pkg::CFG_EPOCH_COUNT:  epoch_count_reg  <= cfg_data[15:0];
                cptp_pkg::CFG_MODE_COUNT:   mode_count_reg   <= cfg_data[2:0];
                cptp_pkg::CFG_LATENT_COUNT: latent_count_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cptp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        sq_start   = 1'b0;
        sq_a       = {quotient[45:0], 16'b0};
        case (state_reg)
            cptp_pkg::ST_IDLE:
            begin
                if (in_xfer && action == cptp_pkg::ACT_EVAL)
                    state_next = (lc_eff == 6'd0) ? cptp_pkg::ST_PRED : cptp_pkg::ST_RUN;
                else if (in_xfer && action == cptp_pkg::ACT_FINISH)
                begin
                    if (entry_count_reg == '0)
                        state_next = cptp_pkg::ST_OUT;
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = raw_sum_reg;
                        div_b      = entry_count_reg;
                        state_next = cptp_pkg::ST_DIV_RAW;
                    end
                end
            end
            cptp_pkg::ST_RUN:
            begin
                if (mode_reg == mc_last && lat_reg == lc_last)
                    state_next = cptp_pkg::ST_DRAIN;
            end
            cptp_pkg::ST_DRAIN:
            begin
                if (!rd_v_reg && !term_v_reg)
                    state_next = cptp_pkg::ST_PRED;
            end
            cptp_pkg::ST_PRED:
                state_next = cptp_pkg::ST_AVG;
            cptp_pkg::ST_AVG:
            begin
                if (epoch_count_reg == '0)
                    state_next = cptp_pkg::ST_MUL_RAW;
                else
                begin
                    div_start  = 1'b1;
                    div_a      = N_W'(delta_abs);
                    div_b      = D_W'({1'b0, epoch_count_reg} + 17'd1);
                    state_next = cptp_pkg::ST_DIV_MEAN;
                end
            end
            cptp_pkg::ST_DIV_MEAN:
                if (div_stat.done)
                    state_next = cptp_pkg::ST_MEAN;
            cptp_pkg::ST_MEAN:    state_next = cptp_pkg::ST_MUL_VAR;
            cptp_pkg::ST_MUL_VAR: state_next = cptp_pkg::ST_VAR;
            cptp_pkg::ST_VAR:     state_next = cptp_pkg::ST_MUL_RAW;
            cptp_pkg::ST_MUL_RAW: state_next = cptp_pkg::ST_ACC_RAW;
            cptp_pkg::ST_ACC_RAW: state_next = cptp_pkg::ST_MUL_AVG;
            cptp_pkg::ST_MUL_AVG: state_next = cptp_pkg::ST_ACC_AVG;
            cptp_pkg::ST_ACC_AVG: state_next = cptp_pkg::ST_OUT;
            cptp_pkg::ST_DIV_RAW:
            begin
                if (div_stat.done)
                begin
                    if (quotient[N_W-1:46] != '0)
                    begin
                        div_start  = 1'b1;
                        div_a      = avg_sum_reg;
                        div_b      = entry_count_reg;
                        state_next = cptp_pkg::ST_DIV_AVG;
                    end
                    else
                    begin
                        sq_start   = 1'b1;
                        state_next = cptp_pkg::ST_SQRT_RAW;
                    end
                end
            end
            cptp_pkg::ST_SQRT_RAW:
            begin
                if (sq_stat.done)
                begin
                    div_start  = 1'b1;
                    div_a      = avg_sum_reg;
                    div_b      = entry_count_reg;
                    state_next = cptp_pkg::ST_DIV_AVG;
                end
            end
            cptp_pkg::ST_DIV_AVG:
            begin
                if (div_stat.done)
                begin
                    if (quotient[N_W-1:46] != '0)
                        state_next = cptp_pkg::ST_OUT;
                    else
                    begin
                        sq_start   = 1'b1;
                        state_next = cptp_pkg::ST_SQRT_AVG;
                    end
                end
            end
            cptp_pkg::ST_SQRT_AVG:
                if (sq_stat.done)
                    state_next = cptp_pkg::ST_OUT;
            cptp_pkg::ST_OUT:
                if (out_free)
                    state_next = cptp_pkg::ST_IDLE;
            default:
                state_next = cptp_pkg::ST_IDLE;
        endcase
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg        <= 1'b0;
            term_v_reg      <= 1'b0;
            raw_sum_reg     <= '0;
            avg_sum_reg     <= '0;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= (state_reg == cptp_pkg::ST_RUN);
            term_v_reg <= rd_v_reg && rd_last_reg;
            if (state_reg == cptp_pkg::ST_ACC_RAW)
                raw_sum_reg <= raw_add[64] ? '1 : raw_add[63:0];
            if (state_reg == cptp_pkg::ST_ACC_AVG)
            begin
                avg_sum_reg <= avg_add[64] ? '1 : avg_add[63:0];
                if (entry_count_reg != '1)
                    entry_count_reg <= entry_count_reg + 32'd1;
            end
            if (state_reg == cptp_pkg::ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                // finish clears the accumulators as its report goes out
                if (rep_reg)
                begin
                    raw_sum_reg     <= '0;
                    avg_sum_reg     <= '0;
                    entry_count_reg <= '0;
                end
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            idx_reg[0] <= first_index;
            idx_reg[1] <= second_index;
            idx_reg[2] <= third_index;
            idx_reg[3] <= fourth_index;
            obs_reg    <= observed;
            pm_reg     <= prior_mean;
            pv_reg     <= prior_var;
            mode_reg   <= '0;
            lat_reg    <= '0;
            sum_reg    <= '0;
            mean_reg   <= '0;
            var_reg    <= '0;
            rr_reg     <= '0;
            ra_reg     <= '0;
            rep_reg    <= (action == cptp_pkg::ACT_FINISH);
            nod_reg    <= (action == cptp_pkg::ACT_FINISH) && (entry_count_reg == '0);
        end

        if (state_reg == cptp_pkg::ST_RUN)
        begin
            rd_first_reg <= (mode_reg == '0);
            rd_last_reg  <= (mode_reg == mc_last);
            if (mode_reg == mc_last)
            begin
                mode_reg <= '0;
                lat_reg  <= lat_reg + 1'b1;
            end
            else
                mode_reg <= mode_reg + 1'b1;
        end

        if (rd_v_reg)
        begin
            t_reg    <= t_new;
            term_reg <= t_new;
        end
        if (term_v_reg)
            sum_reg <= sum_reg + SUM_W'(term_reg);

        case (state_reg)
            cptp_pkg::ST_PRED:
            begin
                if (pred_wide > (SUM_W+1)'(S32_MAX))
                    pred_reg <= S32_MAX;
                else if (pred_wide < (SUM_W+1)'(S32_MIN))
                    pred_reg <= S32_MIN;
                else
                    pred_reg <= pred_wide[31:0];
            end
            cptp_pkg::ST_AVG:
            begin
                if (epoch_count_reg == '0)
                begin
                    mean_reg <= pred_reg;
                    var_reg  <= pv_reg;
                end
            end
            cptp_pkg::ST_MEAN:
                mean_reg <= mean_wide[31:0];
            cptp_pkg::ST_MUL_VAR:
                prod_reg <= 64'(delta_abs * rest_abs);
            cptp_pkg::ST_VAR:
            begin
                if (var_wide > 50'(S32_MAX))
                    var_reg <= S32_MAX;
                else
                    var_reg <= var_wide[31:0];
            end
            cptp_pkg::ST_MUL_RAW:
                prod_reg <= 64'(err_raw_abs * err_raw_abs);
            cptp_pkg::ST_MUL_AVG:
                prod_reg <= 64'(err_avg_abs * err_avg_abs);
            cptp_pkg::ST_DIV_RAW:
                if (div_stat.done && quotient[N_W-1:46] != '0)
                    rr_reg <= RMSE_MAX;
            cptp_pkg::ST_SQRT_RAW:
                if (sq_stat.done)
                    rr_reg <= root;
            cptp_pkg::ST_DIV_AVG:
                if (div_stat.done && quotient[N_W-1:46] != '0)
                    ra_reg <= RMSE_MAX;
            cptp_pkg::ST_SQRT_AVG:
                if (sq_stat.done)
                    ra_reg <= root;
            cptp_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    new_mean_reg  <= mean_reg;
                    new_var_reg   <= var_reg;
                    rmse_raw_reg  <= rr_reg;
                    rmse_avg_reg  <= ra_reg;
                    is_report_reg <= rep_reg;
                    no_data_reg   <= nod_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign new_mean      = new_mean_reg;
    assign new_var       = new_var_reg;
    assign rmse_raw      = rmse_raw_reg;
    assign rmse_averaged = rmse_avg_reg;
    assign is_report     = is_report_reg;
    assign no_data       = no_data_reg;

    `CPTP_ASSERT_SAME(a_div_idle_on_start, div_start, !div_stat.busy,
        "divider started while busy")
    `CPTP_ASSERT_SAME(a_read_in_walk, rd_v_reg,
        state_reg == cptp_pkg::ST_RUN || state_reg == cptp_pkg::ST_DRAIN,
        "factor read data outside the latent walk")
    `CPTP_ASSERT_NEXT(a_finish_clears,
        state_reg == cptp_pkg::ST_OUT && out_free && rep_reg,
        entry_count_reg == '0 && raw_sum_reg == '0 && avg_sum_reg == '0,
        "accumulators not cleared by finish")
    `CPTP_ASSERT_SAME(a_report_no_stats, out_valid && is_report,
        new_mean == '0 && new_var == '0,
        "report carries entry statistics")

endmodule
`default_nettype wire

>>> rtl/cptp_factor_ram.sv
`default_nettype none
module cptp_factor_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/cptp_divider.sv
`default_nettype none
module cptp_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cptp_pkg::DIV_N_W-1:0]  dividend,
    input  wire logic [cptp_pkg::DIV_D_W-1:0]  divisor,
    output logic      [cptp_pkg::DIV_N_W-1:0]  quotient,
    output cptp_pkg::unit_stat_t               stat
);

    localparam int N_W   = cptp_pkg::DIV_N_W;
    localparam int D_W   = cptp_pkg::DIV_D_W;
    localparam int CNT_W = $clog2(N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_W - 1);

    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [N_W-1:0]   quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     shifted;
    logic             ge;

    // One quotient bit per cycle, restoring.
    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign ge      = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? D_W'(shifted - {1'b0, div_reg}) : shifted[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

>>> rtl/cptp_sqrt.sv
`default_nettype none
module cptp_sqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [cptp_pkg::SQ_IN_W-1:0]   radicand,
    output logic      [cptp_pkg::SQ_OUT_W-1:0]  root,
    output cptp_pkg::unit_stat_t                stat
);

    localparam int IN_W  = cptp_pkg::SQ_IN_W;
    localparam int OUT_W = cptp_pkg::SQ_OUT_W;
    localparam int REM_W = OUT_W + 2;
    localparam int CNT_W = $clog2(OUT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_W - 1);

    logic [IN_W-1:0]  rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [OUT_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W+1:0] pre;
    logic [REM_W+1:0] trial;
    logic             ge;

    // Bring down two radicand bits per cycle, settle one root bit.
    assign pre   = {rem_reg, rad_reg[IN_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = pre >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[IN_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(pre - trial) : pre[REM_W-1:0];
            root_reg <= {root_reg[OUT_W-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

>>> tb/sv/tb_cp_tensor_predict_rmse.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_cp_tensor_predict_rmse;

    typedef struct packed {
        cptp_pkg::action_t  act;
        logic [1:0]         lmode;
        logic [4:0]         llat;
        logic [9:0]         lidx;
        logic signed [31:0] lval;
        logic [3:0][9:0]    idx;
        logic signed [31:0] obs;
        logic signed [31:0] pmean;
        logic signed [31:0] pvar;
    } work_t;

    typedef struct packed {
        logic signed [31:0] mean;
        logic signed [31:0] var_s;
        logic [30:0]        raw;
        logic [30:0]        avg;
        logic               rep;
        logic               nod;
    } outcome_t;

    typedef struct {
        work_t    w;
        bit       typed;
        outcome_t res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [1:0]  load_mode;
    logic [4:0]  load_latent;
    logic [9:0]  load_index;
    logic signed [31:0] load_value;
    logic [9:0]  first_index, second_index, third_index, fourth_index;
    logic signed [31:0] observed, prior_mean, prior_var;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] new_mean, new_var;
    logic [30:0] rmse_raw, rmse_averaged;
    logic        is_report, no_data;

    cp_tensor_predict_rmse DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .load_mode(load_mode), .load_latent(load_latent),
        .load_index(load_index), .load_value(load_value),
        .first_index(first_index), .second_index(second_index),
        .third_index(third_index), .fourth_index(fourth_index),
        .observed(observed), .prior_mean(prior_mean), .prior_var(prior_var),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_mean(new_mean), .new_var(new_var),
        .rmse_raw(rmse_raw), .rmse_averaged(rmse_averaged),
        .is_report(is_report), .no_data(no_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow state of the block
    int          factors [int];
    bit [63:0]   raw_sq_sum, avg_sq_sum;
    bit [31:0]   eval_count;
    logic signed [31:0] offset_reg;
    bit [15:0]   epoch_reg;
    bit [2:0]    modes_reg;
    bit [5:0]    latents_reg;

    outcome_t    pending_results[$];
    int          errors = 0;
    bit          burst = 0;
    bit          hold_req = 0;

    // Only these columns are ever loaded, so evaluations read written entries only
    const bit [9:0] cols [4] = '{10'd0, 10'd1023, 10'd341, 10'd682};

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
        bit [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic bit [30:0] root_mean(bit [63:0] sum, bit [31:0] n);
        bit [63:0] v, r, b;
        v = sum / n;
        if (v >= 64'd1 << 46)
            return 31'h7FFFFFFF;
        v = v << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[30:0];
    endfunction

    function automatic longint factor_at(int m, int d, bit [9:0] col);
        return longint'(factors[(m * cptp_pkg::MAX_LATENTS + d) * cptp_pkg::ROWS_PER_MODE
            + col]);
    endfunction

    function automatic bit compute_outcome(work_t w, output outcome_t r);
        int mc, lc;
        longint t, acc, pred, mean, var_s, dlt, rest;
        r = '0;
        case (w.act)
            cptp_pkg::ACT_LOAD:
            begin
                factors[(int'(w.lmode) * cptp_pkg::MAX_LATENTS + w.llat)
                    * cptp_pkg::ROWS_PER_MODE + w.lidx] = w.lval;
                return 0;
            end
            cptp_pkg::ACT_EVAL:
            begin
                mc = modes_reg < 2 ? 2 : (modes_reg > cptp_pkg::MAX_MODES ?
                    cptp_pkg::MAX_MODES : modes_reg);
                lc = latents_reg > cptp_pkg::MAX_LATENTS ? cptp_pkg::MAX_LATENTS
                    : latents_reg;
                acc = 0;
                for (int d = 0; d < lc; d++)
                begin
                    t = factor_at(0, d, w.idx[0]);
                    for (int m = 1; m < mc; m++)
                        t = sat32((t * factor_at(m, d, w.idx[m])) >>> 16);
                    acc += t;
                end
                pred = sat32(longint'(offset_reg) + acc);
                if (epoch_reg == 0)
                begin
                    mean = pred;
                    var_s = w.pvar;
                end
                else
                begin
                    dlt = pred - w.pmean;
                    mean = w.pmean + dlt / (longint'(epoch_reg) + 1);
                    rest = pred - mean;
                    var_s = sat32(w.pvar +
                        longint'((magnitude(dlt) * magnitude(rest)) >> 16));
                end
                raw_sq_sum = add_sat(raw_sq_sum,
                    (magnitude(w.obs - pred) * magnitude(w.obs - pred)) >> 16);
                avg_sq_sum = add_sat(avg_sq_sum,
                    (magnitude(w.obs - mean) * magnitude(w.obs - mean)) >> 16);
                if (eval_count != '1)
                    eval_count++;
                r.mean = mean[31:0];
                r.var_s = var_s[31:0];
                return 1;
            end
            cptp_pkg::ACT_FINISH:
            begin
                r.rep = 1'b1;
                if (eval_count == 0)
                    r.nod = 1'b1;
                else
                begin
                    r.raw = root_mean(raw_sq_sum, eval_count);
                    r.avg = root_mean(avg_sq_sum, eval_count);
                end
                raw_sq_sum = 0;
                avg_sq_sum = 0;
                eval_count = 0;
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic logic [31:0] any_q16();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 65536 * 16)) - 65536 * 8);
            default: return 32'($signed($urandom_range(0, 65536 * 4)) - 65536 * 2);
        endcase
    endfunction

    function automatic work_t rand_load();
        work_t w;
        w = '0;
        w.act = cptp_pkg::ACT_LOAD;
        w.lmode = 2'($urandom);
        w.llat = 5'($urandom);
        w.lidx = cols[$urandom_range(0, 3)];
        w.lval = $urandom_range(0, 9) == 0 ? any_q16() :
            32'($signed($urandom_range(0, 65536 * 4)) - 65536 * 2);
        w.idx = 40'({$urandom, $urandom});
        return w;
    endfunction

    function automatic work_t rand_work();
        work_t w;
        int pick;
        w = '0;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            w.act = cptp_pkg::ACT_LOAD;
        else if (pick < 90)
            w.act = cptp_pkg::ACT_EVAL;
        else if (pick < 97)
            w.act = cptp_pkg::ACT_FINISH;
        else
            w.act = cptp_pkg::ACT_NONE;
        if (w.act == cptp_pkg::ACT_LOAD)
            return rand_load();
        for (int k = 0; k < 4; k++)
            w.idx[k] = cols[$urandom_range(0, 3)];
        w.obs = any_q16();
        w.pmean = any_q16();
        w.pvar = any_q16();
        w.lval = $urandom;
        return w;
    endfunction

    task automatic send_item(work_t w, bit typed, outcome_t want);
        int gap;
        outcome_t r;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= w.act;
        load_mode <= w.lmode;
        load_latent <= w.llat;
        load_index <= w.lidx;
        load_value <= w.lval;
        first_index <= w.idx[0];
        second_index <= w.idx[1];
        third_index <= w.idx[2];
        fourth_index <= w.idx[3];
        observed <= w.obs;
        prior_mean <= w.pmean;
        prior_var <= w.pvar;
        do
            @(posedge clk);
        while (!in_ready);
        if (compute_outcome(w, r))
            pending_results.push_back(typed ? want : r);
    endtask

    // Wait for every result, then let a finished load or ignored item settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] gm, logic [15:0] ep, logic [2:0] mc, logic [5:0] lc);
        cfg_we <= 1'b1;
        cfg_index <= cptp_pkg::CFG_GLOBAL_MEAN;
        cfg_data <= gm;
        @(posedge clk);
        cfg_index <= cptp_pkg::CFG_EPOCH_COUNT;
        cfg_data <= {16'h0, ep};
        @(posedge clk);
        cfg_index <= cptp_pkg::CFG_MODE_COUNT;
        cfg_data <= {29'h0, mc};
        @(posedge clk);
        cfg_index <= cptp_pkg::CFG_LATENT_COUNT;
        cfg_data <= {26'h0, lc};
        @(posedge clk);
        cfg_we <= 1'b0;
        offset_reg = gm;
        epoch_reg = ep;
        modes_reg = mc;
        latents_reg = lc;
    endtask

    localparam logic [39:0] IDX_LOW  = 40'h0;
    localparam logic [39:0] IDX_HIGH = 40'hFFFFFFFFFF;
    localparam logic [39:0] IDX_MIX  = {10'd1023, 10'd0, 10'd682, 10'd341};
    localparam outcome_t    EMPTY_REPORT = '{32'sd0, 32'sd0, 31'd0, 31'd0, 1'b1, 1'b1};

    row_t dir_tab [] = '{
        '{'{cptp_pkg::ACT_EVAL, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_LOW, 32'sh7FFFFFFF,
            32'sh80000000, 32'sh7FFFFFFF}, 1'b0, '0},
        '{'{cptp_pkg::ACT_NONE, 2'd3, 5'd31, 10'd1023, 32'shFFFFFFFF, IDX_HIGH, 32'sh0,
            32'sh0, 32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_EVAL, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_HIGH, 32'sh80000000,
            32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '0},
        '{'{cptp_pkg::ACT_EVAL, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_MIX, 32'sh00010000,
            32'sh0, 32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_FINISH, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_LOW, 32'sh0, 32'sh0,
            32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_FINISH, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_LOW, 32'sh0, 32'sh0,
            32'sh0}, 1'b1, EMPTY_REPORT},
        '{'{cptp_pkg::ACT_LOAD, 2'd3, 5'd31, 10'd1023, 32'sh7FFFFFFF, IDX_LOW, 32'sh0,
            32'sh0, 32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_LOAD, 2'd0, 5'd0, 10'd0, 32'sh80000000, IDX_LOW, 32'sh0,
            32'sh0, 32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_EVAL, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_HIGH, 32'sh0, 32'sh0,
            32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_EVAL, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_LOW, 32'sh0, 32'sh0,
            32'sh0}, 1'b0, '0},
        '{'{cptp_pkg::ACT_FINISH, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_LOW, 32'sh0, 32'sh0,
            32'sh0}, 1'b0, '0}
    };

    initial
    begin
        work_t w;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= cptp_pkg::ACT_NONE;
        load_mode <= '0;
        load_latent <= '0;
        load_index <= '0;
        load_value <= '0;
        first_index <= '0;
        second_index <= '0;
        third_index <= '0;
        fourth_index <= '0;
        observed <= '0;
        prior_mean <= '0;
        prior_var <= '0;
        raw_sq_sum = 0;
        avg_sq_sum = 0;
        eval_count = 0;
        offset_reg = 0;
        epoch_reg = 0;
        modes_reg = 3;
        latents_reg = 32;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing evaluated since reset
        send_item('{cptp_pkg::ACT_FINISH, 2'd0, 5'd0, 10'd0, 32'sh0, IDX_LOW, 32'sh0,
            32'sh0, 32'sh0}, 1'b1, EMPTY_REPORT);
        for (int m = 0; m < cptp_pkg::MAX_MODES; m++)
            for (int d = 0; d < cptp_pkg::MAX_LATENTS; d++)
                for (int c = 0; c < 4; c++)
                begin
                    w = rand_load();
                    w.lmode = 2'(m);
                    w.llat = 5'(d);
                    w.lidx = cols[c];
                    send_item(w, 1'b0, '0);
                end
        foreach (dir_tab[i])
            send_item(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(32'h80000000, 16'd65535, 3'd4, 6'd32);
                1: set_regs(32'h7FFFFFFF, 16'd1, 3'd2, 6'd1);
                2: set_regs($urandom, 16'd7, 3'd0, 6'd0);
                3: set_regs(any_q16(), 16'd0, 3'd7, 6'd63);
                4: set_regs(any_q16(), 16'($urandom_range(1, 100)), 3'd5, 6'd20);
                default: set_regs(any_q16(), 16'($urandom), 3'd1, 6'd33);
            endcase
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < 80; n++)
            begin
                if (n % 40 == 0)
                    burst = $urandom_range(0, 2) == 0;
                send_item(rand_work(), 1'b0, '0);
            end
            burst = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("tb_cp_tensor_predict_rmse: clean");
        else
            $display("tb_cp_tensor_predict_rmse: errors");
        $finish;
    end

    initial
    begin
        int stall;
        outcome_t want;
        out_ready <= 1'b0;
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 4);
            if (hold_req)
            begin
                // Hold off long enough for the block to back up its input
                hold_req = 1'b0;
                stall = 600;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (new_mean !== want.mean)
                begin
                    $display("%0t: new_mean expected %0d got %0d", $time, want.mean, new_mean);
                    errors++;
                end
                if (new_var !== want.var_s)
                begin
                    $display("%0t: new_var expected %0d got %0d", $time, want.var_s, new_var);
                    errors++;
                end
                if (rmse_raw !== want.raw)
                begin
                    $display("%0t: rmse_raw expected %0d got %0d", $time, want.raw, rmse_raw);
                    errors++;
                end
                if (rmse_averaged !== want.avg)
                begin
                    $display("%0t: rmse_averaged expected %0d got %0d", $time, want.avg,
                        rmse_averaged);
                    errors++;
                end
                if (is_report !== want.rep)
                begin
                    $display("%0t: is_report expected %0d got %0d", $time, want.rep, is_report);
                    errors++;
                end
                if (no_data !== want.nod)
                begin
                    $display("%0t: no_data expected %0d got %0d", $time, want.nod, no_data);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb_cp_tensor_predict_rmse: errors");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/cptp_pkg.sv
rtl/cptp_factor_ram.sv
rtl/cptp_divider.sv
rtl/cptp_sqrt.sv
rtl/cp_tensor_predict_rmse.sv
tb/sv/tb_cp_tensor_predict_rmse.sv
